>>> sv/integer_to_radix_digits_macros.svh
// Assertion macros for the integer-to-radix-digits block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// same-cycle implication
`define ITRD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itrd assertion failed: (ante) |-> (cons)");

// next-cycle implication
`define ITRD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itrd assertion failed: (ante) |=> (cons)");

`endif

>>> sv/itrd_pkg.sv
// Package for the integer-to-radix-digits block.
// Holds widths, character codes, the divider command/status types, the state type and glyph().
`timescale 1ns / 1ps

package itrd_pkg;

	localparam int VALUE_W    = 64;
	localparam int CHAR_W     = 7;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 20;
	localparam int IDX_W      = $clog2(MAX_DIGITS);

	localparam int CHUNK_W = 16;
	localparam int CHUNKS  = VALUE_W / CHUNK_W;
	localparam int STEP_W  = $clog2(CHUNKS);
	localparam int DIV_X_W = DIGIT_W + CHUNK_W;
	localparam int PROD_W  = 2 * DIV_X_W;

	// floor(x / 10) == (x * DEC_RECIP) >> DEC_SHIFT for x below 10 * 2^CHUNK_W
	localparam logic [DIV_X_W-1:0] DEC_RECIP = 20'd838861;
	localparam int                 DEC_SHIFT = 23;

	localparam logic MODE_DEC = 1'b0;
	localparam logic MODE_HEX = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE    = 7'h39;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 7'h46;

	typedef struct packed {
		logic               load;
		logic               start;
		logic [VALUE_W-1:0] value;
		logic               mode;
	} div_cmd_t;

	typedef struct packed {
		logic               done;
		logic               zero;
		logic [DIGIT_W-1:0] digit;
	} div_stat_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_DIV   = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d < DIGIT_W'(10))
			return CHAR_ZERO + dx;
		else
			return CHAR_UPPER_A - CHAR_W'(10) + dx;
	endfunction

endpackage

>>> sv/itrd_in_if.sv
// Input channel: one value word with radix mode and signed flag.
// Depends on itrd_pkg.
`timescale 1ns / 1ps

interface itrd_in_if import itrd_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               mode;
	logic               signed_flag;

	modport source (output valid, output value, output mode, output signed_flag, input ready);
	modport sink   (input valid, input value, input mode, input signed_flag, output ready);
endinterface

>>> sv/itrd_out_if.sv
// Output channel: one ASCII character word with a last-character mark.
// Depends on itrd_pkg.
`timescale 1ns / 1ps

interface itrd_out_if import itrd_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last_char;

	modport source (output valid, output character, output last_char, input ready);
	modport sink   (input valid, input character, input last_char, output ready);
endinterface

>>> sv/itrd_divider.sv
// Shared divide unit: yields one digit per request, least significant first.
// Base ten runs CHUNKS reciprocal-multiply steps; base sixteen takes one shift. Uses itrd_pkg.
`timescale 1ns / 1ps

module itrd_divider import itrd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_cmd_t  cmd,
	output div_stat_t stat
);

	logic [VALUE_W-1:0] w_q;
	logic               mode_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [DIGIT_W-1:0] digit_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;

	logic               active;
	logic [DIGIT_W-1:0] rem_in;
	logic [STEP_W-1:0]  idx;
	logic [DIV_X_W-1:0] x;
	logic [PROD_W-1:0]  prod;
	logic [CHUNK_W-1:0] qc;
	logic [DIV_X_W-1:0] qc_ext;
	logic [DIV_X_W-1:0] r;
	logic               last_step;

	assign active    = cmd.start | busy_q;
	assign rem_in    = cmd.start ? '0 : rem_q;
	assign idx       = cmd.start ? '0 : step_q;
	assign x         = {rem_in, w_q[VALUE_W-1 -: CHUNK_W]};
	assign prod      = {{DIV_X_W{1'b0}}, x} * {{DIV_X_W{1'b0}}, DEC_RECIP};
	assign qc        = prod[DEC_SHIFT +: CHUNK_W];
	assign qc_ext    = {{DIGIT_W{1'b0}}, qc};
	assign r         = x - ((qc_ext << 3) + (qc_ext << 1));
	assign last_step = (idx == STEP_W'(CHUNKS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (cmd.load) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (active) begin
			if (mode_q == MODE_HEX) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= STEP_W'(idx + 1'b1);
				busy_q <= !last_step;
				done_q <= last_step;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q    <= cmd.value;
			mode_q <= cmd.mode;
		end else if (active) begin
			if (mode_q == MODE_HEX) begin
				digit_q <= w_q[DIGIT_W-1:0];
				w_q     <= w_q >> DIGIT_W;
			end else begin
				w_q   <= {w_q[VALUE_W-CHUNK_W-1:0], qc};
				rem_q <= r[DIGIT_W-1:0];
				if (last_step)
					digit_q <= r[DIGIT_W-1:0];
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.zero  = (w_q == '0);
	assign stat.digit = digit_q;

endmodule

>>> sv/integer_to_radix_digits.sv
// Each value is converted digit by digit, least significant first, by the shared
// 16-bit-per-cycle divide unit; the text then leaves one character a cycle through the
// output register while that register is empty or text.ready is high.
// A new value is taken once the last character sits in the output register.
// Reset (arst_n low, asynchronous) clears the sequencer, counters and output valid.
// Depends on itrd_pkg, itrd_in_if, itrd_out_if and itrd_divider.
`timescale 1ns / 1ps

module integer_to_radix_digits import itrd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	itrd_in_if.sink         item,
	itrd_out_if.source      text
);

	state_t             state_q, state_d;
	logic               sign_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [DIGIT_W-1:0] store_q [MAX_DIGITS];
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic               accept;
	logic               neg;
	logic [VALUE_W-1:0] mag;
	logic               finish;
	logic               out_load;
	logic               emit;
	div_cmd_t           cmd;
	div_stat_t          stat;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid & item.ready;
	assign neg        = item.signed_flag & item.value[VALUE_W-1];
	assign mag        = neg ? (~item.value + 1'b1) : item.value;
	assign finish     = stat.zero || (cnt_q == IDX_W'(MAX_DIGITS - 1));
	assign out_load   = !out_valid_q || text.ready;
	assign emit       = (state_q == S_OUT) && out_load;

	assign cmd.load  = accept;
	assign cmd.value = mag;
	assign cmd.mode  = item.mode;
	assign cmd.start = (state_q == S_START) ||
		((state_q == S_DIV) && stat.done && !finish);

	itrd_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = S_START;
			S_START: state_d = S_DIV;
			S_DIV:   if (stat.done && finish) state_d = S_OUT;
			S_OUT:   if (out_load && !sign_q && cnt_q == '0) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sign_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sign_q <= neg;
				cnt_q  <= '0;
			end else if (state_q == S_DIV && stat.done && !finish) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (emit) begin
				if (sign_q)
					sign_q <= 1'b0;
				else if (cnt_q != '0)
					cnt_q <= cnt_q - 1'b1;
			end
			if (out_load)
				out_valid_q <= (state_q == S_OUT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV && stat.done)
			store_q[cnt_q] <= stat.digit;
		if (emit) begin
			char_q <= sign_q ? CHAR_MINUS : glyph(store_q[cnt_q]);
			last_q <= !sign_q && (cnt_q == '0);
		end
	end

	assign text.valid     = out_valid_q;
	assign text.character = char_q;
	assign text.last_char = last_q;

endmodule

>>> sv/itrd_checker.sv
// Port-level checks for integer_to_radix_digits, bound to the top level.
// Depends on itrd_pkg and integer_to_radix_digits_macros.svh.
`timescale 1ns / 1ps
`include "integer_to_radix_digits_macros.svh"

module itrd_checker import itrd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] character,
	input logic              last_char
);

	`ITRD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	`ITRD_ASSERT_IMP(a_legal_char, out_valid, (character == CHAR_MINUS) || ((character >= CHAR_ZERO) && (character <= CHAR_NINE)) || ((character >= CHAR_UPPER_A) && (character <= CHAR_UPPER_F)))

	`ITRD_ASSERT_IMP(a_sign_not_last, out_valid && (character == CHAR_MINUS), !last_char)

	`ITRD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(character) && $stable(last_char))

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.character (text.character),
	.last_char (text.last_char)
);
